@@ hw/rtl/ftn_pkg.sv @@
package ftn_pkg;

  // field widths
  localparam int FREQ_W         = 32;
  localparam int REF_W          = 21;
  localparam int FREQ_FRAC_BITS = 12;
  localparam int NOTE_W         = 4;
  localparam int OCT_W          = 6;
  localparam int CENTS_W        = 14;

  localparam logic [REF_W-1:0] REF_A4_RESET = REF_W'(1802240);

  // fixed-point log2: integer part is the leading-one position, 24 fraction bits
  localparam int LOG_FRAC  = 24;
  localparam int EXP_W     = 5;
  localparam int LOG_W     = EXP_W + LOG_FRAC;
  localparam int LOG_CNT_W = 5;
  localparam logic [LOG_CNT_W-1:0] LOG_CNT_LAST = LOG_CNT_W'(LOG_FRAC - 1);

  // log difference and scaling to 1/10000 semitone
  localparam int D_W = 32;
  localparam logic signed [D_W-1:0] LOG_OFFSET =
    D_W'((12 - FREQ_FRAC_BITS) * (1 << LOG_FRAC));
  localparam int T_W = 49;
  localparam logic signed [T_W-1:0] SEMI_SCALE = T_W'(120000);
  // half-unit rounding plus the A4 index, both folded into one add
  localparam logic signed [T_W-1:0] RND_BIAS =
    T_W'((64'sd570000 << LOG_FRAC) + (64'sd1 << (LOG_FRAC - 1)));

  // note rounding by reciprocal multiply, biased so the dividend stays positive
  localparam int IDX_W       = 25;
  localparam int NOTE_SCALE  = 10000;
  localparam int NOTE_BIAS_K = 840;
  localparam logic signed [IDX_W-1:0] NOTE_BIAS =
    IDX_W'(NOTE_SCALE / 2 + NOTE_BIAS_K * NOTE_SCALE);
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_10K = RECIP_W'((64'd1 << RECIP_SHIFT) / NOTE_SCALE);
  localparam int P_W  = IDX_W + RECIP_W;
  localparam int QT_W = P_W - RECIP_SHIFT;
  localparam int R_W  = 15;

  // octave split by reciprocal multiply
  localparam int NOTES_PER_OCT = 12;
  localparam int OCT_SHIFT     = 16;
  localparam int OCT_RECIP_W   = 13;
  localparam logic [OCT_RECIP_W-1:0] OCT_RECIP =
    OCT_RECIP_W'(((1 << OCT_SHIFT) + NOTES_PER_OCT - 1) / NOTES_PER_OCT);
  localparam int P12_W    = QT_W + OCT_RECIP_W;
  localparam int Q12_W    = P12_W - OCT_SHIFT;
  localparam int OCT_BIAS = NOTE_BIAS_K / NOTES_PER_OCT;
  localparam int OCT_MAX  = (1 << (OCT_W - 1)) - 1;
  localparam int OCT_MIN  = -(1 << (OCT_W - 1));

  // decoupling queue and back pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int SQ_STAGES   = LOG_FRAC;
  localparam int BACK_STAGES = SQ_STAGES + 10;

  typedef enum logic [1:0] {
    RL_IDLE,
    RL_NORM,
    RL_SQR
  } rl_state_e;

  // classified item as it travels from front to back
  typedef struct packed {
    logic             zero;
    logic [EXP_W-1:0] e;
    logic [FREQ_W-1:0] x;
  } item_t;

  // reference log as seen by the back pipeline
  typedef struct packed {
    logic             zero;
    logic [LOG_W-1:0] log;
  } ref_info_t;

  typedef struct packed {
    logic [FREQ_W-1:0] m;
    logic              b;
  } sq_t;

  // position of the most significant set bit, zero for a zero word
  function automatic logic [EXP_W-1:0] msb_pos(input logic [FREQ_W-1:0] x);
    logic [EXP_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (x[i]) begin
        pos = EXP_W'(i);
      end
    end
    return pos;
  endfunction

  // one log2 fraction bit: square the Q1.31 mantissa and renormalize
  function automatic sq_t sq_step(input logic [FREQ_W-1:0] m);
    logic [2*FREQ_W-1:0] p;
    logic [FREQ_W:0]     s;
    sq_t                 r;
    p = {{FREQ_W{1'b0}}, m} * {{FREQ_W{1'b0}}, m};
    s = p[2*FREQ_W-1:FREQ_W-1];
    if (s[FREQ_W]) begin
      r.m = s[FREQ_W:1];
      r.b = 1'b1;
    end else begin
      r.m = s[FREQ_W-1:0];
      r.b = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ftn_front.sv @@
module ftn_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ftn_pkg::FREQ_W-1:0] frequency_i,
  input  logic                      hold_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output ftn_pkg::item_t            q_data_o
);
  import ftn_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  ready;
  logic  accept;

  // front register frees up when its item moves into the queue
  assign ready      = !vld_q || !q_full_i;
  assign in_stall_o = !ready || hold_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = vld_q && !q_full_i;
  assign q_data_o   = item_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (q_push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // classify on transfer: zero check and leading-one position
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.zero <= (frequency_i == '0);
      item_q.e    <= msb_pos(frequency_i);
      item_q.x    <= frequency_i;
    end
  end

endmodule

@@ hw/rtl/ftn_queue.sv @@
module ftn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ftn_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output ftn_pkg::item_t data_o,
  output logic           empty_o
);
  import ftn_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/ftn_reflog.sv @@
module ftn_reflog (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ftn_pkg::REF_W-1:0] cfg_wdata_i,
  output logic                     busy_o,
  output ftn_pkg::ref_info_t       ref_o
);
  import ftn_pkg::*;

  rl_state_e             state_q, state_d;
  logic [REF_W-1:0]      ref_q;
  logic [LOG_CNT_W-1:0]  cnt_q, cnt_d;
  logic [FREQ_W-1:0]     m_q, m_d;
  logic [LOG_FRAC-1:0]   bits_q, bits_d;
  logic [EXP_W-1:0]      e_q, e_d;
  logic                  zero_q, zero_d;
  sq_t                   sq;

  assign busy_o    = (state_q != RL_IDLE);
  assign ref_o.zero = zero_q;
  assign ref_o.log  = {e_q, bits_q};

  // normalize once, then one squaring per cycle with a shared squarer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    bits_d  = bits_q;
    e_d     = e_q;
    zero_d  = zero_q;
    sq      = sq_step(m_q);
    case (state_q)
      RL_IDLE: begin
        state_d = RL_IDLE;
      end
      RL_NORM: begin
        e_d     = msb_pos(FREQ_W'(ref_q));
        m_d     = FREQ_W'(ref_q) << (EXP_W'(FREQ_W - 1) - e_d);
        zero_d  = (ref_q == '0);
        bits_d  = '0;
        cnt_d   = '0;
        state_d = RL_SQR;
      end
      RL_SQR: begin
        m_d    = sq.m;
        bits_d = {bits_q[LOG_FRAC-2:0], sq.b};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LOG_CNT_LAST) begin
          state_d = RL_IDLE;
        end
      end
      default: begin
        state_d = RL_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      state_d = RL_NORM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RL_NORM;
      cnt_q   <= '0;
      ref_q   <= REF_A4_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        ref_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    bits_q <= bits_d;
    e_q    <= e_d;
    zero_q <= zero_d;
  end

endmodule

@@ hw/rtl/ftn_back.sv @@
module ftn_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  ftn_pkg::item_t                    q_data_i,
  output logic                              q_pop_o,
  input  ftn_pkg::ref_info_t                ref_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ftn_pkg::NOTE_W-1:0]        note_class_o,
  output logic signed [ftn_pkg::OCT_W-1:0]  octave_number_o,
  output logic signed [ftn_pkg::CENTS_W-1:0] cents_offset_o,
  output logic                              valid_res_o
);
  import ftn_pkg::*;

  // stage positions after the squaring stages
  localparam int ST_D   = SQ_STAGES + 1;
  localparam int ST_OUT = BACK_STAGES - 1;

  logic                   en;
  logic [BACK_STAGES-1:0] vld_q;
  logic [BACK_STAGES-1:0] zero_q, zero_d;

  logic [FREQ_W-1:0]   m_q    [0:SQ_STAGES];
  logic [LOG_FRAC-1:0] bits_q [0:SQ_STAGES];
  logic [EXP_W-1:0]    e_q    [0:SQ_STAGES];
  sq_t                 sq     [1:SQ_STAGES];
  logic [FREQ_W-1:0]   norm_m;

  logic [LOG_W-1:0]         lf;
  logic signed [D_W-1:0]    d_q, d_d;
  logic signed [T_W-1:0]    t_q, t_d;
  logic signed [T_W-1:0]    rnd_sum;
  logic signed [IDX_W-1:0]  idx_q, idx_d;
  logic signed [IDX_W-1:0]  vs;
  logic [IDX_W-1:0]         v_q, v2_q;
  logic [2:0]               neg_q;
  logic [P_W-1:0]           p_q, p_d;
  logic [QT_W-1:0]          qt, qt_q;
  logic [R_W-1:0]           r0_q, r0_d, r;
  logic [QT_W-1:0]          qtc_q, qtc_d, qtc2_q;
  logic [CENTS_W-1:0]       cents_q, cents_d, cents2_q;
  logic [P12_W-1:0]         p12_q, p12_d;
  logic [Q12_W-1:0]         q12;
  logic [QT_W-1:0]          cls_full;
  logic signed [Q12_W:0]    oct_full;
  logic signed [OCT_W-1:0]  oct_sat;

  // whole pipeline advances unless a finished result is held
  assign en          = !(out_valid_o && out_stall_i);
  assign q_pop_o     = en && !q_empty_i;
  assign out_valid_o = vld_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BACK_STAGES-2:0], q_pop_o};
    end
  end

  // zero flag shifts along, a zero reference joins it at the difference stage
  always_comb begin
    zero_d       = {zero_q[BACK_STAGES-2:0], q_data_i.zero};
    zero_d[ST_D] = zero_q[ST_D-1] | ref_i.zero;
  end

  // mantissa normalization and log2 squaring chain
  assign norm_m = q_data_i.x << (EXP_W'(FREQ_W - 1) - q_data_i.e);

  always_comb begin
    for (int k = 1; k <= SQ_STAGES; k++) begin
      sq[k] = sq_step(m_q[k-1]);
    end
  end

  // log difference, scale and rounding
  assign lf    = {e_q[SQ_STAGES], bits_q[SQ_STAGES]};
  assign d_d   = $signed(D_W'(lf)) - $signed(D_W'(ref_i.log)) + LOG_OFFSET;
  assign t_d   = T_W'(d_q) * SEMI_SCALE;
  assign rnd_sum = t_q + RND_BIAS - $signed(T_W'(t_q[T_W-1]));
  assign idx_d = IDX_W'(rnd_sum >>> LOG_FRAC);
  assign vs    = idx_q + NOTE_BIAS - $signed(IDX_W'(idx_q[IDX_W-1]));

  // note by reciprocal multiply, with one correction step
  assign p_d  = P_W'(v_q) * P_W'(RECIP_10K);
  assign qt   = p_q[P_W-1:RECIP_SHIFT];
  assign r0_d = R_W'(v2_q - IDX_W'(qt) * IDX_W'(NOTE_SCALE));

  always_comb begin
    if (r0_q >= R_W'(NOTE_SCALE)) begin
      qtc_d = qt_q + 1'b1;
      r     = r0_q - R_W'(NOTE_SCALE);
    end else begin
      qtc_d = qt_q;
      r     = r0_q;
    end
    cents_d = CENTS_W'(r) - CENTS_W'(NOTE_SCALE / 2) + CENTS_W'(neg_q[2]);
  end

  // octave and class from the biased note
  assign p12_d    = P12_W'(qtc_q) * P12_W'(OCT_RECIP);
  assign q12      = p12_q[P12_W-1:OCT_SHIFT];
  assign cls_full = qtc2_q - QT_W'(q12) * QT_W'(NOTES_PER_OCT);
  assign oct_full = $signed({1'b0, q12}) - (Q12_W + 1)'(OCT_BIAS);

  always_comb begin
    if (oct_full > OCT_MAX) begin
      oct_sat = OCT_W'(OCT_MAX);
    end else if (oct_full < OCT_MIN) begin
      oct_sat = OCT_W'(OCT_MIN);
    end else begin
      oct_sat = OCT_W'(oct_full);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q    <= zero_d;
      m_q[0]    <= norm_m;
      e_q[0]    <= q_data_i.e;
      bits_q[0] <= '0;
      for (int k = 1; k <= SQ_STAGES; k++) begin
        m_q[k]    <= sq[k].m;
        e_q[k]    <= e_q[k-1];
        bits_q[k] <= {bits_q[k-1][LOG_FRAC-2:0], sq[k].b};
      end
      d_q      <= d_d;
      t_q      <= t_d;
      idx_q    <= idx_d;
      v_q      <= $unsigned(vs);
      neg_q    <= {neg_q[1:0], idx_q[IDX_W-1]};
      p_q      <= p_d;
      v2_q     <= v_q;
      qt_q     <= qt;
      r0_q     <= r0_d;
      qtc_q    <= qtc_d;
      cents_q  <= cents_d;
      p12_q    <= p12_d;
      qtc2_q   <= qtc_q;
      cents2_q <= cents_q;
      if (zero_q[ST_OUT-1]) begin
        note_class_o    <= '0;
        octave_number_o <= '0;
        cents_offset_o  <= '0;
        valid_res_o     <= 1'b0;
      end else begin
        note_class_o    <= cls_full[NOTE_W-1:0];
        octave_number_o <= oct_sat;
        cents_offset_o  <= $signed(cents2_q);
        valid_res_o     <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/frequency_to_note_and_cents.sv @@
// Frequency to equal-tempered note, octave and cents.
// Input channel: frequency_i (Hz, 12 fraction bits) with in_valid_i / in_stall_o;
// a transfer happens on a rising edge with valid high and stall low.
// Output channel: note_class_o, octave_number_o, cents_offset_o, valid_res_o with
// out_valid_o / out_stall_i, same transfer rule; one result per input item.
// Configuration: cfg_we_i writes cfg_wdata_i to the A4 reference.
// An item travels from input transfer to out_valid_o through one front register,
// the queue, the normalization register, the 24 squaring stages of the log2
// and 9 arithmetic stages. Throughput is one item per cycle when nothing stalls,
// set by the fully pipelined back end. After reset and after every reference
// write, in_stall_o is high while a shared squarer computes the reference log2.
// When the receiver stalls, the result holds and the back pipeline freezes;
// the front keeps taking items until the 4-entry queue and front register fill.
// A zero frequency or zero reference gives valid_res_o low and zero fields.
module frequency_to_note_and_cents (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ftn_pkg::FREQ_W-1:0]         frequency_i,
  input  logic                               cfg_we_i,
  input  logic [ftn_pkg::REF_W-1:0]          cfg_wdata_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ftn_pkg::NOTE_W-1:0]         note_class_o,
  output logic signed [ftn_pkg::OCT_W-1:0]   octave_number_o,
  output logic signed [ftn_pkg::CENTS_W-1:0] cents_offset_o,
  output logic                               valid_res_o
);
  import ftn_pkg::*;

  item_t     push_data, pop_data;
  logic      q_push, q_pop, q_full, q_empty;
  logic      ref_busy;
  ref_info_t ref_info;

  // front: input transfer and classification
  ftn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .frequency_i (frequency_i),
    .hold_i      (ref_busy),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (push_data)
  );

  // decoupling queue
  ftn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (pop_data),
    .empty_o (q_empty)
  );

  // reference register and its log2
  ftn_reflog u_reflog (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (ref_busy),
    .ref_o       (ref_info)
  );

  // back: log2 pipeline and note arithmetic
  ftn_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (pop_data),
    .q_pop_o         (q_pop),
    .ref_i           (ref_info),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .note_class_o    (note_class_o),
    .octave_number_o (octave_number_o),
    .cents_offset_o  (cents_offset_o),
    .valid_res_o     (valid_res_o)
  );

endmodule

@@ hw/rtl/ftn_checker.sv @@
module ftn_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               cfg_we_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [ftn_pkg::NOTE_W-1:0]         note_class_o,
  input logic signed [ftn_pkg::OCT_W-1:0]   octave_number_o,
  input logic signed [ftn_pkg::CENTS_W-1:0] cents_offset_o,
  input logic                               valid_res_o
);
  import ftn_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(note_class_o) &&
      $stable(octave_number_o) && $stable(cents_offset_o) && $stable(valid_res_o))
    else $error("output changed while stalled");

  // an invalid result carries zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |->
      note_class_o == '0 && octave_number_o == '0 && cents_offset_o == '0)
    else $error("invalid result with nonzero fields");

  // a valid result stays within note and cents range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |->
      note_class_o <= NOTE_W'(NOTES_PER_OCT - 1) &&
      cents_offset_o >= -CENTS_W'(NOTE_SCALE / 2) &&
      cents_offset_o <= CENTS_W'(NOTE_SCALE / 2))
    else $error("result out of range");

  // reference write blocks input while its log is recomputed
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input not stalled after reference write");

endmodule

bind frequency_to_note_and_cents ftn_checker u_ftn_checker (.*);
